/* src/lli_pkg.sv */
// Shared types for the two-line intersection pipeline.
// No dependencies; used by lli_div and line_line_intersection_2d.
`timescale 1ns / 1ps

package lli_pkg;

   // Sign of one coordinate's numerator and overflow of its quotient, carried with the quotient.
   typedef struct packed {
      logic neg;
      logic ovf;
   } lli_flags_type;

   // Per-stage control that travels beside the data path.
   typedef struct packed {
      logic valid;
      logic par;
      logic seg;
   } lli_side_type;

endpackage

/* src/lli_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on lli_pkg for the flag struct that rides along with each quotient.
`timescale 1ns / 1ps

module lli_div import lli_pkg::*; #(
   parameter int QuoW = 32,
   parameter int DenW = 67
) (
   input  logic                clock,
   input  logic [DenW-1:0]     rem_start,
   input  logic [QuoW-1:0]     nlow_start,
   input  logic [DenW-1:0]     den_start,
   input  lli_flags_type       flags_start,
   output logic [QuoW-1:0]     quo,
   output lli_flags_type       flags_done
);

   logic [DenW-1:0]  rem_ff   [QuoW];
   logic [QuoW-1:0]  nlow_ff  [QuoW];
   logic [DenW-1:0]  den_ff   [QuoW];
   logic [QuoW-1:0]  quo_ff   [QuoW];
   lli_flags_type    flags_ff [QuoW];

   for (genvar g = 0; g < QuoW; g++) begin : g_step
      logic [DenW-1:0] rem_src;
      logic [QuoW-1:0] nlow_src;
      logic [DenW-1:0] den_src;
      logic [QuoW-1:0] quo_src;
      lli_flags_type   flags_src;
      logic [DenW:0]   trial;
      logic [DenW:0]   diff;

      if (g == 0) begin : g_first
         assign rem_src   = rem_start;
         assign nlow_src  = nlow_start;
         assign den_src   = den_start;
         assign quo_src   = '0;
         assign flags_src = flags_start;
      end else begin : g_next
         assign rem_src   = rem_ff[g-1];
         assign nlow_src  = nlow_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign quo_src   = quo_ff[g-1];
         assign flags_src = flags_ff[g-1];
      end

      // shift in the next numerator bit, subtract when it does not borrow
      assign trial = {rem_src, nlow_src[QuoW-1]};
      assign diff  = trial - {1'b0, den_src};

      always_ff @(posedge clock) begin
         rem_ff[g]   <= diff[DenW] ? trial[DenW-1:0] : diff[DenW-1:0];
         quo_ff[g]   <= {quo_src[QuoW-2:0], ~diff[DenW]};
         nlow_ff[g]  <= nlow_src << 1;
         den_ff[g]   <= den_src;
         flags_ff[g] <= flags_src;
      end
   end

   assign quo        = quo_ff[QuoW-1];
   assign flags_done = flags_ff[QuoW-1];

endmodule

/* src/line_line_intersection_2d.sv */
// Top level of the two-line intersection block: exact fixed-point pipeline.
// Depends on lli_pkg and lli_div.
`timescale 1ns / 1ps

// Intersection of line one (start, end) with line two (start, end), all
// signed fixed point with FRAC_BITS fractional bits. A transaction is taken
// on every clock where start is high; busy stays low, since every stage
// moves forward each cycle and the receiver cannot stall. Each transaction
// gives exactly one result, shown for one cycle with rsp_valid, after it
// passes through eight arithmetic stages (differences, products,
// determinant, sign fixup, partial products, two adds, magnitude), one
// stage per quotient bit of the divider that forms each coordinate, and
// the output register. Results come out in order, one per cycle at most.
// Parallel lines (|det| below csr epsilon, or det zero) give the largest
// positive coordinates with rsp_lines_parallel set. Write the epsilon
// only while no transaction is in
// flight.

module line_line_intersection_2d import lli_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_line1_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_line1_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_line1_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_line1_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_line2_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_line2_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_line2_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_line2_end_y,
   input  logic                          csr_write_enable,
   input  logic [31:0]                   csr_write_data,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y,
   output logic                          rsp_on_first_segment,
   output logic                          rsp_lines_parallel,
   output logic                          rsp_coord_saturated
);

   localparam int W       = COORD_WIDTH;
   localparam int DiffW   = W + 1;
   localparam int ProdW   = 2 * DiffW;
   localparam int DetW    = ProdW + 1;
   localparam int LoW     = DetW / 2;
   localparam int HiW     = DetW - LoW;
   localparam int NumW    = W + DetW + 2;
   localparam int PreLat  = 8;
   localparam int Lat     = PreLat + W;
   localparam logic [31:0] EpsReset =
      (2 * FRAC_BITS > 23) ? (32'd1 << (2 * FRAC_BITS - 23)) : 32'd1;
   localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MinMag = {1'b1, {(W-1){1'b0}}};

   // the pipeline never holds off a transaction
   assign busy = 1'b0;

   // epsilon register
   logic [31:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsReset;
      end else if (csr_write_enable) begin
         eps_ff <= csr_write_data;
      end
   end

   // control beside the data: valid, parallel verdict, segment verdict
   lli_side_type side_ff [Lat];
   lli_side_type side_in [Lat];

   // stage 1: coordinate differences
   logic signed [W-1:0]     x1_1_ff, y1_1_ff;
   logic signed [DiffW-1:0] dirx_1_ff, diry_1_ff;
   logic signed [DiffW-1:0] dx12_ff, dy12_ff, dx34_ff, dy34_ff, dx13_ff, dy13_ff;

   always_ff @(posedge clock) begin
      x1_1_ff   <= req_line1_start_x;
      y1_1_ff   <= req_line1_start_y;
      dirx_1_ff <= DiffW'(req_line1_end_x) - DiffW'(req_line1_start_x);
      diry_1_ff <= DiffW'(req_line1_end_y) - DiffW'(req_line1_start_y);
      dx12_ff   <= DiffW'(req_line1_start_x) - DiffW'(req_line1_end_x);
      dy12_ff   <= DiffW'(req_line1_start_y) - DiffW'(req_line1_end_y);
      dx34_ff   <= DiffW'(req_line2_start_x) - DiffW'(req_line2_end_x);
      dy34_ff   <= DiffW'(req_line2_start_y) - DiffW'(req_line2_end_y);
      dx13_ff   <= DiffW'(req_line1_start_x) - DiffW'(req_line2_start_x);
      dy13_ff   <= DiffW'(req_line1_start_y) - DiffW'(req_line2_start_y);
   end

   // stage 2: the four cross products
   logic signed [W-1:0]     x1_2_ff, y1_2_ff;
   logic signed [DiffW-1:0] dirx_2_ff, diry_2_ff;
   logic signed [ProdW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;

   always_ff @(posedge clock) begin
      x1_2_ff   <= x1_1_ff;
      y1_2_ff   <= y1_1_ff;
      dirx_2_ff <= dirx_1_ff;
      diry_2_ff <= diry_1_ff;
      p1_ff     <= dy12_ff * dx34_ff;
      p2_ff     <= dx12_ff * dy34_ff;
      p3_ff     <= dx13_ff * dy34_ff;
      p4_ff     <= dy13_ff * dx34_ff;
   end

   // stage 3: determinant and numerator of t
   logic signed [W-1:0]     x1_3_ff, y1_3_ff;
   logic signed [DiffW-1:0] dirx_3_ff, diry_3_ff;
   logic signed [DetW-1:0]  det_ff, num_3_ff;

   always_ff @(posedge clock) begin
      x1_3_ff   <= x1_2_ff;
      y1_3_ff   <= y1_2_ff;
      dirx_3_ff <= dirx_2_ff;
      diry_3_ff <= diry_2_ff;
      det_ff    <= DetW'(p1_ff) - DetW'(p2_ff);
      num_3_ff  <= DetW'(p3_ff) - DetW'(p4_ff);
   end

   // stage 4: parallel test, make the denominator -det positive
   logic [DetW-1:0]         det_abs;
   logic                    det_zero;
   logic                    par_in;
   logic signed [W-1:0]     x1_4_ff, y1_4_ff;
   logic signed [DiffW-1:0] dirx_4_ff, diry_4_ff;
   logic [DetW-1:0]         den_4_ff;
   logic signed [DetW-1:0]  num_4_ff;

   assign det_abs  = det_ff[DetW-1] ? DetW'(-det_ff) : DetW'(det_ff);
   assign det_zero = (det_ff == '0);
   assign par_in   = det_zero || (det_abs < {{(DetW-32){1'b0}}, eps_ff});

   always_ff @(posedge clock) begin
      x1_4_ff   <= x1_3_ff;
      y1_4_ff   <= y1_3_ff;
      dirx_4_ff <= dirx_3_ff;
      diry_4_ff <= diry_3_ff;
      den_4_ff  <= det_abs;
      // a positive det flips the numerator along with the denominator
      num_4_ff  <= (det_ff[DetW-1] || det_zero) ? num_3_ff : -num_3_ff;
   end

   // stage 5: segment test, partial products of start*den and dir*num
   logic                          seg_in;
   logic signed [W+LoW:0]         sxl_ff, syl_ff;
   logic signed [W+HiW:0]         sxh_ff, syh_ff;
   logic signed [DiffW+LoW:0]     dxl_ff, dyl_ff;
   logic signed [DiffW+HiW-1:0]   dxh_ff, dyh_ff;
   logic [DetW-1:0]               den_5_ff;

   assign seg_in = !num_4_ff[DetW-1] && (DetW'(num_4_ff) <= den_4_ff);

   always_ff @(posedge clock) begin
      sxl_ff   <= x1_4_ff * $signed({1'b0, den_4_ff[LoW-1:0]});
      syl_ff   <= y1_4_ff * $signed({1'b0, den_4_ff[LoW-1:0]});
      sxh_ff   <= x1_4_ff * $signed({1'b0, den_4_ff[DetW-1:LoW]});
      syh_ff   <= y1_4_ff * $signed({1'b0, den_4_ff[DetW-1:LoW]});
      dxl_ff   <= dirx_4_ff * $signed({1'b0, num_4_ff[LoW-1:0]});
      dyl_ff   <= diry_4_ff * $signed({1'b0, num_4_ff[LoW-1:0]});
      dxh_ff   <= dirx_4_ff * $signed(num_4_ff[DetW-1:LoW]);
      dyh_ff   <= diry_4_ff * $signed(num_4_ff[DetW-1:LoW]);
      den_5_ff <= den_4_ff;
   end

   // stage 6: recombine the partial products
   logic signed [NumW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [DetW-1:0]        den_6_ff;

   always_ff @(posedge clock) begin
      ax_ff    <= NumW'(sxl_ff) + (NumW'(sxh_ff) <<< LoW);
      ay_ff    <= NumW'(syl_ff) + (NumW'(syh_ff) <<< LoW);
      bx_ff    <= NumW'(dxl_ff) + (NumW'(dxh_ff) <<< LoW);
      by_ff    <= NumW'(dyl_ff) + (NumW'(dyh_ff) <<< LoW);
      den_6_ff <= den_5_ff;
   end

   // stage 7: coordinate numerators start*den + dir*num
   logic signed [NumW-1:0] nx_ff, ny_ff;
   logic [DetW-1:0]        den_7_ff;

   always_ff @(posedge clock) begin
      nx_ff    <= ax_ff + bx_ff;
      ny_ff    <= ay_ff + by_ff;
      den_7_ff <= den_6_ff;
   end

   // stage 8: magnitude, overflow check, first divider remainder
   logic [NumW-1:0]   nx_abs, ny_abs;
   logic [NumW-W-1:0] hx, hy;
   logic [DetW-1:0]   remx_ff, remy_ff, den_8_ff;
   logic [W-1:0]      nlowx_ff, nlowy_ff;
   lli_flags_type     flx_ff, fly_ff;

   assign nx_abs = nx_ff[NumW-1] ? NumW'(-nx_ff) : NumW'(nx_ff);
   assign ny_abs = ny_ff[NumW-1] ? NumW'(-ny_ff) : NumW'(ny_ff);
   assign hx     = nx_abs[NumW-1:W];
   assign hy     = ny_abs[NumW-1:W];

   always_ff @(posedge clock) begin
      remx_ff    <= hx[DetW-1:0];
      remy_ff    <= hy[DetW-1:0];
      nlowx_ff   <= nx_abs[W-1:0];
      nlowy_ff   <= ny_abs[W-1:0];
      den_8_ff   <= den_7_ff;
      flx_ff.neg <= nx_ff[NumW-1];
      fly_ff.neg <= ny_ff[NumW-1];
      // quotient needs more than W bits when the high part reaches den
      flx_ff.ovf <= (hx >= {2'b0, den_7_ff});
      fly_ff.ovf <= (hy >= {2'b0, den_7_ff});
   end

   // divider lanes, one per coordinate
   logic [W-1:0]  qx, qy;
   lli_flags_type fdx, fdy;

   lli_div #(.QuoW(W), .DenW(DetW)) u_div_x (
      .clock       (clock),
      .rem_start   (remx_ff),
      .nlow_start  (nlowx_ff),
      .den_start   (den_8_ff),
      .flags_start (flx_ff),
      .quo         (qx),
      .flags_done  (fdx)
   );

   lli_div #(.QuoW(W), .DenW(DetW)) u_div_y (
      .clock       (clock),
      .rem_start   (remy_ff),
      .nlow_start  (nlowy_ff),
      .den_start   (den_8_ff),
      .flags_start (fly_ff),
      .quo         (qy),
      .flags_done  (fdy)
   );

   // advance the control line; stage 4 sets the parallel bit, stage 5 the segment bit
   always_comb begin
      for (int i = 0; i < Lat; i++) begin
         if (i == 0) begin
            side_in[i] = '{valid: start, par: 1'b0, seg: 1'b0};
         end else begin
            side_in[i] = side_ff[i-1];
         end
      end
      side_in[3].par = par_in;
      side_in[4].seg = seg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < Lat; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // output stage: clamp to W bits, restore sign, override for parallel lines
   logic [W-1:0] limx, limy, magx, magy;
   logic         satx, saty;
   logic         valid_out_ff, par_out_ff, seg_out_ff, sat_out_ff;
   logic [W-1:0] cx_out_ff, cy_out_ff;
   lli_side_type side_last;

   assign side_last = side_ff[Lat-1];
   assign limx = fdx.neg ? MinMag : MaxPos;
   assign limy = fdy.neg ? MinMag : MaxPos;
   assign satx = fdx.ovf || (qx > limx);
   assign saty = fdy.ovf || (qy > limy);
   assign magx = satx ? limx : qx;
   assign magy = saty ? limy : qy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else begin
         valid_out_ff <= side_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      par_out_ff <= side_last.par;
      if (side_last.par) begin
         cx_out_ff  <= MaxPos;
         cy_out_ff  <= MaxPos;
         seg_out_ff <= 1'b0;
         sat_out_ff <= 1'b0;
      end else begin
         cx_out_ff  <= fdx.neg ? -magx : magx;
         cy_out_ff  <= fdy.neg ? -magy : magy;
         seg_out_ff <= side_last.seg;
         sat_out_ff <= satx || saty;
      end
   end

   assign rsp_valid            = valid_out_ff;
   assign rsp_cross_x          = cx_out_ff;
   assign rsp_cross_y          = cy_out_ff;
   assign rsp_on_first_segment = seg_out_ff;
   assign rsp_lines_parallel   = par_out_ff;
   assign rsp_coord_saturated  = sat_out_ff;

endmodule

/* tb/tb_line_line_intersection_2d.sv */
// Testbench for line_line_intersection_2d: directed and random line pairs, exact prediction.
// Depends on lli_pkg and line_line_intersection_2d, which in turn needs lli_div.
`timescale 1ns / 1ps

module tb_line_line_intersection_2d;
   import lli_pkg::*;

   localparam int CW       = 32;
   localparam int LATENCY  = 9 + CW;
   localparam int EPS_INIT = 512;
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE   = 32'sh0001_0000;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   } line_pair_type;

   typedef struct packed {
      logic signed [CW-1:0] cx, cy;
      logic                 seg, par, sat;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   line_pair_type pair_in = '0;
   logic csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic rsp_valid;
   logic signed [CW-1:0] rsp_cross_x, rsp_cross_y;
   logic rsp_on_first_segment, rsp_lines_parallel, rsp_coord_saturated;

   logic [31:0]  epsilon_now = EPS_INIT;  // testbench copy of the register
   crossing_type pending_crossings[$];
   int           fail_count = 0;

   line_line_intersection_2d #(.COORD_WIDTH(CW), .FRAC_BITS(16)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_line1_start_x(pair_in.x1), .req_line1_start_y(pair_in.y1),
      .req_line1_end_x(pair_in.x2),   .req_line1_end_y(pair_in.y2),
      .req_line2_start_x(pair_in.x3), .req_line2_start_y(pair_in.y3),
      .req_line2_end_x(pair_in.x4),   .req_line2_end_y(pair_in.y4),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_on_first_segment(rsp_on_first_segment),
      .rsp_lines_parallel(rsp_lines_parallel),
      .rsp_coord_saturated(rsp_coord_saturated)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs.
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Clamp one exact quotient to the coordinate range.
   function automatic logic signed [CW-1:0] clamp_coord(input wide_type q, inout logic sat);
      if (q > wide_type'(C_MAX)) begin
         sat = 1'b1;
         return C_MAX;
      end
      if (q < wide_type'(C_MIN)) begin
         sat = 1'b1;
         return C_MIN;
      end
      return q[CW-1:0];
   endfunction

   // Exact intersection in 128-bit signed integers; division truncates toward zero.
   function automatic crossing_type intersect_lines(input line_pair_type p,
                                                    input logic [31:0] eps);
      wide_type x1, y1, x2, y2, x3, y3, x4, y4, dx34, dy34, det, num, den, mag;
      crossing_type r;
      logic sat;
      x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
      x3 = p.x3; y3 = p.y3; x4 = p.x4; y4 = p.y4;
      dx34 = x3 - x4;
      dy34 = y3 - y4;
      det  = (y1 - y2) * dx34 - (x1 - x2) * dy34;
      mag  = (det < 0) ? -det : det;
      r = '0;
      if (det == 0 || mag < wide_type'({96'd0, eps})) begin
         r.cx  = C_MAX;
         r.cy  = C_MAX;
         r.par = 1'b1;
         return r;
      end
      num = (x1 - x3) * dy34 - (y1 - y3) * dx34;
      den = -det;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      sat  = 1'b0;
      r.cx = clamp_coord((x1 * den + (x2 - x1) * num) / den, sat);
      r.cy = clamp_coord((y1 * den + (y2 - y1) * num) / den, sat);
      r.seg = (num >= 0) && (num <= den);
      r.sat = sat;
      return r;
   endfunction

   // Drive one transaction and hold it until the block takes it.
   task automatic send_line_pair(input line_pair_type p);
      @(negedge clock);
      pair_in = p;
      start   = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_crossings.push_back(intersect_lines(p, epsilon_now));
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start   = 1'b0;
         pair_in = '0;
      end
   endtask

   // Drain the pipeline, then write the epsilon register while nothing is in flight.
   task automatic write_epsilon(input logic [31:0] value);
      idle_cycles(1);
      while (pending_crossings.size() != 0) @(negedge clock);
      idle_cycles(LATENCY + 4);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      epsilon_now      = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = $urandom;
   endtask

   function automatic logic signed [CW-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3: return -1;
         4: return ONE;
         default: return $urandom;
      endcase
   endfunction

   // Mostly modest coordinates so results land on and off the segment; some full range.
   function automatic line_pair_type random_line_pair();
      line_pair_type p;
      int mode;
      mode = $urandom_range(0, 9);
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (mode < 6) begin
         p.x1 = $signed(p.x1) >>> 12; p.y1 = $signed(p.y1) >>> 12;
         p.x2 = $signed(p.x2) >>> 12; p.y2 = $signed(p.y2) >>> 12;
         p.x3 = $signed(p.x3) >>> 12; p.y3 = $signed(p.y3) >>> 12;
         p.x4 = $signed(p.x4) >>> 12; p.y4 = $signed(p.y4) >>> 12;
      end else if (mode == 6) begin
         // near-parallel: line two is line one with each endpoint moved by a tiny offset
         p.x3 = p.x1 + $signed($urandom_range(0, 4));
         p.y3 = p.y1 + 1;
         p.x4 = p.x2 + $signed($urandom_range(0, 4));
         p.y4 = p.y2 + $signed($urandom_range(0, 2));
      end else if (mode == 7) begin
         p.x1 = pick_extreme(); p.y1 = pick_extreme();
         p.x2 = pick_extreme(); p.y2 = pick_extreme();
         p.x3 = pick_extreme(); p.y3 = pick_extreme();
         p.x4 = pick_extreme(); p.y4 = pick_extreme();
      end
      return p;
   endfunction

   // Send in bursts of random length, most followed by a random gap; some bursts run long.
   task automatic send_random_bursts(input int count);
      int burst;
      while (count > 0) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_line_pair(random_line_pair());
            count--;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
   endtask

   task automatic test_directed_geometry();
      line_pair_type p;
      // crossing axes: t is one half
      send_line_pair('{-ONE, '0, ONE, '0, '0, -ONE, '0, ONE});
      // line two passes through line one's start: t is zero
      send_line_pair('{'0, '0, ONE, ONE, '0, '0, ONE, -ONE});
      // line two passes through line one's end: t is one
      send_line_pair('{'0, '0, ONE, ONE, ONE, ONE, 2 * ONE, '0});
      // intersection behind the start: t negative
      send_line_pair('{ONE, '0, 2 * ONE, '0, '0, -ONE, '0, ONE});
      // coincident lines: zero determinant
      send_line_pair('{'0, '0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE});
      // parallel offset lines
      send_line_pair('{'0, '0, ONE, '0, '0, ONE, ONE, ONE});
      // determinant at and just below the reset epsilon
      send_line_pair('{'0, '0, 32'sd1, '0, '0, 32'sd0, '0, 32'sd512});
      send_line_pair('{'0, '0, 32'sd1, '0, '0, 32'sd0, '0, 32'sd511});
      // all points the same extreme
      send_line_pair({8{C_MAX}});
      send_line_pair({8{C_MIN}});
      // far extrapolation to force clamping
      send_line_pair('{C_MIN, C_MIN, C_MAX, C_MIN + 1, C_MIN, C_MAX, C_MAX, C_MAX - 2});
      send_line_pair('{C_MAX, '0, C_MIN, 32'sd1, '0, C_MIN, 32'sd1, C_MAX});
      for (int i = 0; i < 10; i++) begin
         p = '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
               pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
         send_line_pair(p);
      end
      idle_cycles(2);
   endtask

   task automatic test_epsilon_settings();
      write_epsilon('0);             // only an exact zero determinant is parallel
      send_line_pair('{'0, '0, 32'sd1, '0, '0, 32'sd0, '0, 32'sd1});
      send_line_pair('{'0, '0, ONE, '0, '0, ONE, ONE, ONE});
      send_random_bursts(60);
      write_epsilon(32'hFFFF_FFFF);  // widest parallel window
      send_random_bursts(60);
      write_epsilon($urandom);
      send_random_bursts(60);
   endtask

   task automatic test_random_traffic();
      write_epsilon($urandom_range(0, 4096));
      send_random_bursts(400);
      write_epsilon(EPS_INIT);
      send_random_bursts(400);
   endtask

   // Scoreboard: compare each result strobe with the oldest prediction.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid) begin
         if (pending_crossings.size() == 0) begin
            $error("unexpected result cross_x=%0d cross_y=%0d", rsp_cross_x, rsp_cross_y);
            fail_count++;
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_cross_x !== want.cx) begin
               $error("cross_x expected %0d actual %0d", want.cx, rsp_cross_x);
               fail_count++;
            end
            if (rsp_cross_y !== want.cy) begin
               $error("cross_y expected %0d actual %0d", want.cy, rsp_cross_y);
               fail_count++;
            end
            if (rsp_on_first_segment !== want.seg) begin
               $error("on_first_segment expected %0b actual %0b", want.seg,
                      rsp_on_first_segment);
               fail_count++;
            end
            if (rsp_lines_parallel !== want.par) begin
               $error("lines_parallel expected %0b actual %0b", want.par,
                      rsp_lines_parallel);
               fail_count++;
            end
            if (rsp_coord_saturated !== want.sat) begin
               $error("coord_saturated expected %0b actual %0b", want.sat,
                      rsp_coord_saturated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_geometry();
      test_epsilon_settings();
      test_random_traffic();

      // Wait for the last results, then give stray strobes a chance to show.
      idle_cycles(1);
      while (pending_crossings.size() != 0) @(negedge clock);
      idle_cycles(LATENCY + 10);
      if (fail_count == 0 && pending_crossings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* line_line_intersection_2d.f */
src/lli_pkg.sv
src/lli_div.sv
src/line_line_intersection_2d.sv
tb/tb_line_line_intersection_2d.sv
